/* design/bcc_pkg.sv */
package bcc_pkg;

	localparam int COUNT_W = 13;
	localparam int CFG_W = 4;
	localparam int EPOCH_W = 8;

	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		logic bit_req;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] distinct_count;
		logic               all_seen;
		logic               is_last;
	} out_item_t;

	typedef enum logic [1:0] {
		CLR_RUN,
		CLR_DRAIN,
		CLR_SWEEP
	} clr_state_t;

	typedef struct packed {
		logic   busy;
		logic   sweep_we;
		epoch_t epoch;
	} ctl_t;

endpackage

/* design/bcc_seen_ram.sv */
module bcc_seen_ram #(
	parameter int AW = 12,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bcc_epoch_ctrl.sv */
module bcc_epoch_ctrl #(
	parameter int AW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            bump,
	input  logic            s1_busy,
	output bcc_pkg::ctl_t   ctl,
	output logic [AW-1:0]   sweep_addr
);

	localparam bcc_pkg::epoch_t EPOCH_FIRST = bcc_pkg::epoch_t'(1);
	localparam bcc_pkg::epoch_t EPOCH_LAST = '1;

	bcc_pkg::clr_state_t state_q, state_nx;
	bcc_pkg::epoch_t     epoch_q;
	logic [AW-1:0]       addr_q;
	logic                sweep_end;

	assign sweep_end = (addr_q == '1);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bcc_pkg::CLR_RUN: begin
				if (bump && epoch_q == EPOCH_LAST) begin
					state_nx = bcc_pkg::CLR_DRAIN;
				end
			end
			bcc_pkg::CLR_DRAIN: begin
				if (!s1_busy) begin
					state_nx = bcc_pkg::CLR_SWEEP;
				end
			end
			bcc_pkg::CLR_SWEEP: begin
				if (sweep_end) begin
					state_nx = bcc_pkg::CLR_RUN;
				end
			end
			default: state_nx = bcc_pkg::CLR_SWEEP;
		endcase
	end

	always_comb begin
		ctl.busy     = 1'b1;
		ctl.sweep_we = 1'b0;
		ctl.epoch    = epoch_q;
		unique case (state_q)
			bcc_pkg::CLR_RUN: begin
				ctl.busy = 1'b0;
			end
			bcc_pkg::CLR_DRAIN: begin
				ctl.busy = 1'b1;
			end
			bcc_pkg::CLR_SWEEP: begin
				ctl.sweep_we = 1'b1;
			end
			default: ctl.busy = 1'b1;
		endcase
	end

	assign sweep_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcc_pkg::CLR_SWEEP;
			epoch_q <= EPOCH_FIRST;
			addr_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == bcc_pkg::CLR_SWEEP) begin
				addr_q <= addr_q + 1'b1;
				if (sweep_end) begin
					epoch_q <= EPOCH_FIRST;
				end
			end else begin
				addr_q <= '0;
				if (state_q == bcc_pkg::CLR_RUN && bump && epoch_q != EPOCH_LAST) begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/binary_code_coverage_check.sv */
// each accepted item is registered in s1, and its result then in the output register
// throughput: one item per cycle unless a clearing pass or out_stall holds
// input; the seen map is one epoch-tagged ram with a single read-modify-write per item, same-code items forwarded
// reset: a clearing pass writes all 2**MAX_CODE_LEN map entries, one per
// cycle, and input is stalled meanwhile; the same pass runs again (after
// the last item drains) each time 255 strings have ended or length writes
// have been taken
module binary_code_coverage_check #(
	parameter int MAX_CODE_LEN = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bcc_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bcc_pkg::out_item_t            out_data
);

	localparam int AW = MAX_CODE_LEN;
	localparam int KW = $clog2(MAX_CODE_LEN + 1);
	localparam int CW = MAX_CODE_LEN + 1;
	localparam int CNT_W = bcc_pkg::COUNT_W;
	localparam int EW = bcc_pkg::EPOCH_W;

	bcc_pkg::ctl_t ctl;
	logic [AW-1:0] sweep_addr;

	logic [bcc_pkg::CFG_W-1:0] code_length_q;
	logic [KW-1:0]             k_eff;
	logic [AW-1:0]             kmask;

	logic [AW-1:0] window_q, win_nx, code_nx;
	logic [KW-1:0] filled_q, filled_nx;
	logic          mark_nx;
	logic          in_accept;

	logic          s1_valid_q, s1_adv;
	logic [AW-1:0] code_s1;
	logic          mark_s1, last_s1;
	logic [EW-1:0] epoch_s1;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_code_q;
	logic [EW-1:0] fwd_epoch_q;

	logic [EW-1:0] rd_epoch;
	logic          hit, is_new;
	logic [CW-1:0] distinct_q, dist_nx, pow_k;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;

	logic               out_valid_q;
	bcc_pkg::out_item_t out_data_q;

	// effective code length, zero as one, saturated at the maximum
	always_comb begin
		if (code_length_q == '0) begin
			k_eff = KW'(1);
		end else if (int'(code_length_q) > MAX_CODE_LEN) begin
			k_eff = KW'(MAX_CODE_LEN);
		end else begin
			k_eff = KW'(code_length_q);
		end
	end

	for (genvar i = 0; i < AW; i++) begin : g_mask
		assign kmask[i] = (KW'(i) < k_eff);
	end

	assign in_accept = in_valid && !in_stall;
	assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = ctl.busy || (s1_valid_q && !s1_adv);

	assign win_nx    = (window_q << 1) | AW'(in_data.bit_req);
	assign filled_nx = (filled_q == KW'(MAX_CODE_LEN)) ? filled_q : filled_q + 1'b1;
	assign mark_nx   = (filled_nx >= k_eff);
	assign code_nx   = win_nx & kmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= bcc_pkg::CFG_W'(1);
			window_q      <= '0;
			filled_q      <= '0;
		end else if (cfg_we) begin
			code_length_q <= cfg_wdata;
			window_q      <= '0;
			filled_q      <= '0;
		end else if (in_accept) begin
			window_q <= in_data.last ? '0 : win_nx;
			filled_q <= in_data.last ? '0 : filled_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			code_s1  <= code_nx;
			mark_s1  <= mark_nx;
			last_s1  <= in_data.last;
			epoch_s1 <= ctl.epoch;
		end
	end

	bcc_epoch_ctrl #(
		.AW(AW)
	) u_epoch_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.bump       ((in_accept && in_data.last) || cfg_we),
		.s1_busy    (s1_valid_q),
		.ctl        (ctl),
		.sweep_addr (sweep_addr)
	);

	// a map entry counts as seen when it holds the item's string epoch, or when the last new code written matches it
	assign hit = (rd_epoch == epoch_s1)
		|| (fwd_valid_q && fwd_code_q == code_s1 && fwd_epoch_q == epoch_s1);
	assign is_new  = mark_s1 && !hit;
	assign dist_nx = distinct_q + CW'(is_new);
	assign pow_k   = CW'(1) << k_eff;

	assign ram_we    = ctl.sweep_we || (s1_adv && is_new);
	assign ram_waddr = ctl.sweep_we ? sweep_addr : code_s1;
	assign ram_wdata = ctl.sweep_we ? '0 : epoch_s1;

	bcc_seen_ram #(
		.AW(AW),
		.DW(EW)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (code_nx),
		.rdata (rd_epoch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (ctl.sweep_we) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_adv && is_new) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && is_new) begin
			fwd_code_q  <= code_s1;
			fwd_epoch_q <= epoch_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distinct_q <= '0;
		end else if (cfg_we) begin
			distinct_q <= '0;
		end else if (s1_adv) begin
			distinct_q <= last_s1 ? '0 : dist_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.distinct_count <= CNT_W'(dist_nx);
			out_data_q.all_seen       <= (dist_nx == pow_k);
			out_data_q.is_last        <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
